@@ sv/tfsi_pkg.sv @@
package tfsi_pkg;

	// output class codes
	typedef enum logic [1:0] {
		CLS_SLOW   = 2'd0,
		CLS_MEDIUM = 2'd1,
		CLS_FAST   = 2'd2
	} cls_t;

	// weight breakpoints in Q4
	localparam logic [8:0] W_LO  = 9'd80;
	localparam logic [8:0] W_MID = 9'd160;
	localparam logic [8:0] W_HI  = 9'd240;
	// height breakpoints in Q4
	localparam logic [7:0] H_LO  = 8'd32;
	localparam logic [7:0] H_MID = 8'd96;
	localparam logic [7:0] H_HI  = 8'd160;

	localparam int unsigned SPEED_MAX = 3072;

	// class from the sum of the two label indices
	function automatic cls_t class_of(input logic [1:0] hi, input logic [1:0] wi);
		logic [2:0] s;
		s = {1'b0, hi} + {1'b0, wi};
		if (s <= 3'd1) return CLS_SLOW;
		else if (s == 3'd2) return CLS_MEDIUM;
		else return CLS_FAST;
	endfunction

	// indices of the strongest and runner-up label, ties to the lower index
	function automatic logic [3:0] top_two(input logic [16:0] m0, input logic [16:0] m1,
		input logic [16:0] m2);
		logic [1:0] a;
		logic [1:0] b;
		a = 2'd0;
		if (m1 > m0) a = 2'd1;
		if (a == 2'd0) begin
			if (m2 > m0) a = 2'd2;
		end else begin
			if (m2 > m1) a = 2'd2;
		end
		unique case (a)
			2'd0: b = (m2 > m1) ? 2'd2 : 2'd1;
			2'd1: b = (m2 > m0) ? 2'd2 : 2'd0;
			default: b = (m1 > m0) ? 2'd1 : 2'd0;
		endcase
		return {b, a};
	endfunction

endpackage

@@ sv/tfsi_fuzz.sv @@
// stage 1: fuzzify both inputs into three memberships each
module tfsi_fuzz import tfsi_pkg::*; #(
	parameter int MU_FRAC_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   vin,
	input  logic [8:0]             weight_q4,
	input  logic [7:0]             height_q4,
	output logic                   v_s1,
	output logic [MU_FRAC_BITS:0]  wmu_s1 [3],
	output logic [MU_FRAC_BITS:0]  hmu_s1 [3]
);
	localparam int MW = MU_FRAC_BITS + 1;
	localparam int RW = 7 + MU_FRAC_BITS;
	localparam int QW = MU_FRAC_BITS + 3;
	localparam int KW = 20;
	localparam int KS = 22;
	localparam logic [KW-1:0] RECIP5 = 20'd838861;
	localparam logic [MW-1:0] ONE = MW'(1) << MU_FRAC_BITS;

	logic [MW-1:0] wmu [3];
	logic [MW-1:0] hmu [3];

	// ramp of the weight: distance scaled by 2^F over 80, the factor 16 folded
	// into the shift and the 5 taken by a reciprocal multiply, exact below 2^22
	function automatic logic [MW-1:0] wramp(input logic [8:0] d);
		logic [QW-1:0]    m;
		logic [QW+KW-1:0] p;
		m = QW'(d) << (MU_FRAC_BITS - 4);
		p = (QW+KW)'(m) * (QW+KW)'(RECIP5);
		return MW'(p >> KS);
	endfunction

	// ramp of the height: distance below 64, shift by 6
	function automatic logic [MW-1:0] hramp(input logic [7:0] d);
		logic [RW-1:0] n;
		n = RW'(d) << MU_FRAC_BITS;
		return MW'(n >> 6);
	endfunction

	// weight memberships
	always_comb begin
		wmu[0] = '0; wmu[1] = '0; wmu[2] = '0;
		if (weight_q4 != 9'd0) begin
			if (weight_q4 <= W_LO) wmu[0] = ONE;
			else if (weight_q4 < W_MID) wmu[0] = wramp(W_MID - weight_q4);
			if (weight_q4 > W_LO && weight_q4 < W_MID) wmu[1] = wramp(weight_q4 - W_LO);
			else if (weight_q4 == W_MID) wmu[1] = ONE;
			else if (weight_q4 > W_MID && weight_q4 < W_HI)
				wmu[1] = wramp(W_HI - weight_q4);
			if (weight_q4 > W_MID && weight_q4 < W_HI) wmu[2] = wramp(weight_q4 - W_MID);
			else if (weight_q4 >= W_HI) wmu[2] = ONE;
		end
	end

	// height memberships
	always_comb begin
		hmu[0] = '0; hmu[1] = '0; hmu[2] = '0;
		if (height_q4 != 8'd0) begin
			if (height_q4 <= H_LO) hmu[0] = ONE;
			else if (height_q4 < H_MID) hmu[0] = hramp(H_MID - height_q4);
			if (height_q4 > H_LO && height_q4 < H_MID) hmu[1] = hramp(height_q4 - H_LO);
			else if (height_q4 == H_MID) hmu[1] = ONE;
			else if (height_q4 > H_MID && height_q4 < H_HI)
				hmu[1] = hramp(H_HI - height_q4);
			if (height_q4 > H_MID && height_q4 < H_HI) hmu[2] = hramp(height_q4 - H_MID);
			else if (height_q4 >= H_HI) hmu[2] = ONE;
		end
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= vin;
	end

	// membership registers
	always_ff @(posedge clk) begin
		if (en) begin
			wmu_s1 <= wmu;
			hmu_s1 <= hmu;
		end
	end
endmodule

@@ sv/tfsi_rules.sv @@
// stages 2 and 3: rule selection, strengths, then weighted products
module tfsi_rules import tfsi_pkg::*; #(
	parameter int MU_FRAC_BITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        v_s1,
	input  logic [MU_FRAC_BITS:0]       wmu_s1 [3],
	input  logic [MU_FRAC_BITS:0]       hmu_s1 [3],
	output logic                        v_s3,
	output logic [2*MU_FRAC_BITS+5:0]   num_s3,
	output logic [MU_FRAC_BITS+1:0]     den_s3,
	output cls_t                        c1_s3,
	output cls_t                        c2_s3
);
	localparam int MW = MU_FRAC_BITS + 1;
	localparam int ZW = MU_FRAC_BITS + 5;
	localparam int PW = 2 * MU_FRAC_BITS + 6;
	localparam logic [ZW-1:0] ONE = ZW'(1) << MU_FRAC_BITS;

	logic [3:0]    wsel, hsel;
	logic [MW-1:0] a1, a2, b1, b2;
	logic          v_s2;
	logic [MW-1:0] s1_s2, s2_s2;
	cls_t          c1_s2, c2_s2;
	logic [ZW-1:0] z1, z2;
	logic [PW-1:0] p1, p2;

	function automatic logic [ZW-1:0] rule_out(input cls_t c, input logic [MW-1:0] a);
		logic [ZW-1:0] a4;
		a4 = ZW'(a) << 2;
		unique case (c)
			CLS_SLOW:   return (ONE << 3) - a4;
			CLS_MEDIUM: return (ONE << 2) + a4;
			default:    return (ONE << 3) + a4;
		endcase
	endfunction

	// choose labels and form strengths
	always_comb begin
		wsel = top_two(17'(wmu_s1[0]), 17'(wmu_s1[1]), 17'(wmu_s1[2]));
		hsel = top_two(17'(hmu_s1[0]), 17'(hmu_s1[1]), 17'(hmu_s1[2]));
		a1 = wmu_s1[wsel[1:0]];
		a2 = wmu_s1[wsel[3:2]];
		b1 = hmu_s1[hsel[1:0]];
		b2 = hmu_s1[hsel[3:2]];
	end

	// rule outputs and products
	always_comb begin
		z1 = rule_out(c1_s2, s1_s2);
		z2 = rule_out(c2_s2, s2_s2);
		p1 = PW'(s1_s2) * PW'(z1);
		p2 = PW'(s2_s2) * PW'(z2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s1_s2  <= (a1 < b1) ? a1 : b1;
			s2_s2  <= (a2 < b2) ? a2 : b2;
			c1_s2  <= class_of(hsel[1:0], wsel[1:0]);
			c2_s2  <= class_of(hsel[3:2], wsel[3:2]);
			num_s3 <= p1 + p2;
			den_s3 <= (MU_FRAC_BITS+2)'(s1_s2) + (MU_FRAC_BITS+2)'(s2_s2);
			c1_s3  <= c1_s2;
			c2_s3  <= c2_s2;
		end
	end
endmodule

@@ sv/tfsi_div.sv @@
// pipelined restoring divider, one quotient bit per stage
module tfsi_div import tfsi_pkg::*; #(
	parameter int MU_FRAC_BITS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       v_in,
	input  logic [2*MU_FRAC_BITS+5:0]  num,
	input  logic [MU_FRAC_BITS+1:0]    den,
	input  cls_t                       c1,
	input  cls_t                       c2,
	output logic                       v_out,
	output logic [11:0]                speed,
	output logic                       none,
	output cls_t                       c1_out,
	output cls_t                       c2_out
);
	// quotient = (num<<8) / (den<<F) = num / (den << (F-8))
	// saturated at 3072, so 13 quotient bits suffice after a high overflow check
	localparam int NW = 2 * MU_FRAC_BITS + 6;
	localparam int DW = MU_FRAC_BITS + 2;
	localparam int SH = MU_FRAC_BITS - 8;
	localparam int QB = 13;
	localparam int RW = DW + QB + 1;
	localparam int XW = NW + 8;
	localparam int N  = QB;

	// dividend widened by 8 bits, and shifted up instead of scaling the divisor when F < 8
	logic [XW-1:0] xnum;
	logic [RW+NW-1:0] dsc;
	assign xnum = (SH >= 0) ? XW'(num) : (XW'(num) << (-SH));

	logic [N:0]       v_p;
	logic [XW-1:0]    rem_p [N+1];
	logic [RW+NW-1:0] d_p [N+1];
	logic [QB-1:0]    q_p [N+1];
	logic             ovf_p [N+1];
	logic             z_p [N+1];
	cls_t             c1_p [N+1];
	cls_t             c2_p [N+1];

	assign dsc = (SH >= 0) ? ((RW+NW)'(den) << ((SH >= 0) ? SH : 0)) : (RW+NW)'(den);

	// entry stage: a quotient of 2^13 or more saturates anyway
	always_comb begin
		v_p[0]   = v_in;
		rem_p[0] = xnum;
		d_p[0]   = dsc;
		q_p[0]   = '0;
		ovf_p[0] = ((RW+NW+QB)'(xnum) >= ((RW+NW+QB)'(dsc) << QB));
		z_p[0]   = (den == '0);
		c1_p[0]  = c1;
		c2_p[0]  = c2;
	end

	for (genvar i = 0; i < N; i++) begin : g_st
		localparam int B = N - 1 - i;
		logic [RW+NW+QB-1:0] t;
		logic                ge;
		assign t  = (RW+NW+QB)'(d_p[i]) << B;
		assign ge = (RW+NW+QB)'(rem_p[i]) >= t;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_p[i+1] <= 1'b0;
			else if (en) v_p[i+1] <= v_p[i];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_p[i+1] <= ge ? XW'((RW+NW+QB)'(rem_p[i]) - t) : rem_p[i];
				q_p[i+1]   <= q_p[i] | (ge ? (QB'(1) << B) : '0);
				d_p[i+1]   <= d_p[i];
				ovf_p[i+1] <= ovf_p[i];
				z_p[i+1]   <= z_p[i];
				c1_p[i+1]  <= c1_p[i];
				c2_p[i+1]  <= c2_p[i];
			end
		end
	end

	// saturate and force zero when no rule fired
	always_comb begin
		v_out  = v_p[N];
		none   = z_p[N];
		c1_out = c1_p[N];
		c2_out = c2_p[N];
		if (z_p[N]) speed = '0;
		else if (ovf_p[N] || q_p[N] > QB'(SPEED_MAX)) speed = 12'(SPEED_MAX);
		else speed = q_p[N][11:0];
	end
endmodule

@@ sv/two_input_fuzzy_speed_inference.sv @@
// channel  dir  fields (low bit first)
// s_axis   in   tdata: weight_q4[8:0], height_q4[16:9]
// m_axis   out  tdata: speed_q8[11:0], no_rule_fired[12], first_class[14:13],
//                      second_class[16:15]
// one item enters per cycle while the output is not stalled; the path is 3 stages plus
// 13 divider stages plus an output register, set by the one-bit-per-stage quotient pipeline
// arst_n clears all valid bits; payload registers are not reset
// a stalled output holds the whole pipeline; input ready follows the output
// side in the same cycle so nothing is lost or repeated
module two_input_fuzzy_speed_inference import tfsi_pkg::*; #(
	parameter int MU_FRAC_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // weight_q4, height_q4
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata    // speed_q8, no_rule_fired, first_class, second_class
);
	logic                      en;
	logic                      v_s1, v_s3, v_d;
	logic [MU_FRAC_BITS:0]     wmu_s1 [3];
	logic [MU_FRAC_BITS:0]     hmu_s1 [3];
	logic [2*MU_FRAC_BITS+5:0] num_s3;
	logic [MU_FRAC_BITS+1:0]   den_s3;
	cls_t                      c1_s3, c2_s3, c1_d, c2_d;
	logic [11:0]               speed_d;
	logic                      none_d;
	logic                      out_v_q;
	logic [16:0]               out_d_q;

	// pipeline moves when the output register is free or being drained
	assign en = !out_v_q || m_axis_tready;
	assign s_axis_tready = en;

	tfsi_fuzz #(.MU_FRAC_BITS(MU_FRAC_BITS)) u_fuzz (
		.clk, .arst_n, .en, .vin(s_axis_tvalid),
		.weight_q4(s_axis_tdata[8:0]), .height_q4(s_axis_tdata[16:9]),
		.v_s1, .wmu_s1, .hmu_s1
	);

	tfsi_rules #(.MU_FRAC_BITS(MU_FRAC_BITS)) u_rules (
		.clk, .arst_n, .en, .v_s1, .wmu_s1, .hmu_s1,
		.v_s3, .num_s3, .den_s3, .c1_s3, .c2_s3
	);

	tfsi_div #(.MU_FRAC_BITS(MU_FRAC_BITS)) u_div (
		.clk, .arst_n, .en, .v_in(v_s3), .num(num_s3), .den(den_s3),
		.c1(c1_s3), .c2(c2_s3), .v_out(v_d), .speed(speed_d), .none(none_d),
		.c1_out(c1_d), .c2_out(c2_d)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (en) out_v_q <= v_d;
	end

	always_ff @(posedge clk) begin
		if (en) out_d_q <= {c2_d, c1_d, none_d, speed_d};
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {7'd0, out_d_q};
endmodule
